[rtl/btdc_pkg.sv]
// Shared types and constants for the blob track direction counter.
`default_nettype none

package btdc_pkg;

    // Fixed field widths of the item and result ports
    localparam int FIELD_W  = 12;
    localparam int AREA_W   = 24;
    localparam int THR_W    = 12;
    localparam int AGE_W    = 8;
    localparam int TALLY_W  = 16;
    localparam int HELD_W   = 5;
    localparam int EVENT_W  = 3;

    // Configuration port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [AREA_W-1:0] MIN_AREA_RST  = 24'd17000;
    localparam logic [AREA_W-1:0] MAX_AREA_RST  = 24'd300000;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 12'd50;
    localparam logic [AGE_W-1:0]  MAX_AGE_RST   = 8'd10;

    localparam logic [AGE_W-1:0] AGE_SAT = '1;

    // Item opcodes
    localparam logic OP_BLOB  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    typedef enum logic [1:0] {
        REG_MIN_AREA  = 2'd0,
        REG_MAX_AREA  = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_MAX_AGE   = 2'd3
    } reg_idx_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_IN    = 3'd1,
        EV_OUT   = 3'd2,
        EV_EVICT = 3'd3,
        EV_DROP  = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [AREA_W-1:0] min_area_x2;
        logic [AREA_W-1:0] max_area_x2;
        logic [THR_W-1:0]  travel_threshold;
        logic [AGE_W-1:0]  max_age;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_done;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/btdc_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none

module btdc_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [btdc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [btdc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [btdc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output btdc_pkg::cfg_t                         cfg
);
    import btdc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Decode a write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_AREA:  cfg_next.min_area_x2      = pwdata[AREA_W-1:0];
                REG_MAX_AREA:  cfg_next.max_area_x2      = pwdata[AREA_W-1:0];
                REG_THRESHOLD: cfg_next.travel_threshold = pwdata[THR_W-1:0];
                REG_MAX_AGE:   cfg_next.max_age          = pwdata[AGE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_area_x2      <= MIN_AREA_RST;
            cfg_reg.max_area_x2      <= MAX_AREA_RST;
            cfg_reg.travel_threshold <= THRESHOLD_RST;
            cfg_reg.max_age          <= MAX_AGE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_AREA:  prdata = APB_DATA_W'(cfg_reg.min_area_x2);
            REG_MAX_AREA:  prdata = APB_DATA_W'(cfg_reg.max_area_x2);
            REG_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.travel_threshold);
            REG_MAX_AGE:   prdata = APB_DATA_W'(cfg_reg.max_age);
        endcase
    end

endmodule

`default_nettype wire

[rtl/btdc_ctrl.sv]
// Controller state machine: accept, walk the track table, commit the result.
`default_nettype none

module btdc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  btdc_pkg::dp_status_t      status,
    output btdc_pkg::ctl_cmd_t        cmd
);
    import btdc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Commit only once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until its transfer
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready) |=> state_reg == ST_FINISH)
        else $error("result committed over an untaken result");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in work");
`endif

endmodule

`default_nettype wire

[rtl/btdc_dp.sv]
// Datapath: track table memory, containment and aging walk, eviction and tallies.
`default_nettype none

module btdc_dp #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  btdc_pkg::cfg_t                       cfg,
    input  btdc_pkg::ctl_cmd_t                   cmd,
    output btdc_pkg::dp_status_t                 status,
    input  wire logic                            op,
    input  wire logic [btdc_pkg::FIELD_W-1:0]    box_x,
    input  wire logic [btdc_pkg::FIELD_W-1:0]    box_y,
    input  wire logic [btdc_pkg::FIELD_W-1:0]    box_w,
    input  wire logic [btdc_pkg::FIELD_W-1:0]    box_h,
    input  wire logic [btdc_pkg::AREA_W-1:0]     area_x2,
    output logic      [btdc_pkg::EVENT_W-1:0]    event_res,
    output logic      [btdc_pkg::TALLY_W-1:0]    count_in,
    output logic      [btdc_pkg::TALLY_W-1:0]    count_out,
    output logic      [btdc_pkg::HELD_W-1:0]     tracks_held
);
    import btdc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
    localparam int EXT_W  = FIELD_W + CB;
    localparam int CMP_W  = (CB > THR_W) ? CB : THR_W;
    localparam logic [CNT_W-1:0] TRACK_LIM = CNT_W'(MAX_TRACKS);
    localparam logic [CB-1:0]    COORD_MAX = '1;

    // Fit an input field to the coordinate width
    function automatic logic [CB-1:0] to_coord(input logic [FIELD_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[CB-1:0];
    endfunction

    // Box center (2*p+len)/2, rounded half to even, saturated
    function automatic logic [CB-1:0] center(input logic [CB-1:0] p,
                                             input logic [CB-1:0] len);
        logic [CB+1:0] s;
        logic [CB:0]   q;
        s = {1'b0, p, 1'b0} + (CB+2)'(len);
        q = s[CB+1:1];
        if (s[0] && q[0])
        begin
            q = q + 1'b1;
        end
        if (q > (CB+1)'(COORD_MAX))
        begin
            q = (CB+1)'(COORD_MAX);
        end
        return q[CB-1:0];
    endfunction

    // Ring address of the entry at an offset from the head
    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(MAX_TRACKS))
        begin
            s = s - (CNT_W+1)'(MAX_TRACKS);
        end
        return s[IDX_W-1:0];
    endfunction

    // Track table memory
    logic [CB-1:0]    mem_sx  [MAX_TRACKS];
    logic [CB-1:0]    mem_cx  [MAX_TRACKS];
    logic [CB-1:0]    mem_cy  [MAX_TRACKS];
    logic [AGE_W-1:0] mem_age [MAX_TRACKS];

    // Item registers
    logic             op_reg;
    logic             area_ok_reg;
    logic [CB-1:0]    bx_reg;
    logic [CB-1:0]    by_reg;
    logic [CB-1:0]    bw_reg;
    logic [CB-1:0]    bh_reg;
    logic [CB-1:0]    cx_reg;
    logic [CB-1:0]    cy_reg;

    // Table control
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [CNT_W-1:0] idx_reg;
    logic             matched_reg;
    logic [TALLY_W-1:0] tally_in_reg;
    logic [TALLY_W-1:0] tally_in_next;
    logic [TALLY_W-1:0] tally_out_reg;
    logic [TALLY_W-1:0] tally_out_next;
    event_t           ev_reg;
    event_t           ev_next;

    // Read stage
    logic             rd_vld_reg;
    logic             rd_first_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic [CB-1:0]    rd_sx_reg;
    logic [CB-1:0]    rd_cx_reg;
    logic [CB-1:0]    rd_cy_reg;
    logic [AGE_W-1:0] rd_age_reg;

    // Head snapshot after aging
    logic [CB-1:0]    head_sx_reg;
    logic [CB-1:0]    head_cx_reg;
    logic [AGE_W-1:0] head_age_reg;

    logic             walk_en;
    logic             issue;
    logic [IDX_W-1:0] raddr;
    logic             inside_x;
    logic             inside_y;
    logic             hit;
    logic [AGE_W-1:0] age_inc;
    logic             append;
    logic             drop;
    logic             evict;
    logic             go_out;
    logic             go_in;
    logic [CB-1:0]    diff_out;
    logic [CB-1:0]    diff_in;

    logic             mem_we;
    logic [IDX_W-1:0] waddr;
    logic [CB-1:0]    wsx;
    logic [CB-1:0]    wcx;
    logic [CB-1:0]    wcy;
    logic [AGE_W-1:0] wage;

    logic [CNT_W+HELD_W-1:0] held_ext;

    assign walk_en = (op_reg == OP_FRAME) || area_ok_reg;
    assign issue   = cmd.walk && walk_en && (idx_reg < total_reg);
    assign raddr   = ring_addr(head_reg, idx_reg);
    assign status.walk_done = (!walk_en || idx_reg == total_reg) && !rd_vld_reg;

    // Containment of a held center in the box, sums without wrap
    assign inside_x = (rd_cx_reg >= bx_reg) &&
                      ((CB+1)'(rd_cx_reg) < (CB+1)'(bx_reg) + (CB+1)'(bw_reg));
    assign inside_y = (rd_cy_reg >= by_reg) &&
                      ((CB+1)'(rd_cy_reg) < (CB+1)'(by_reg) + (CB+1)'(bh_reg));
    assign hit      = rd_vld_reg && (op_reg == OP_BLOB) && inside_x && inside_y;
    assign age_inc  = (rd_age_reg == AGE_SAT) ? rd_age_reg : rd_age_reg + 1'b1;

    // Outcome of the item
    assign append   = (op_reg == OP_BLOB) && area_ok_reg && !matched_reg &&
                      (total_reg < TRACK_LIM);
    assign drop     = (op_reg == OP_BLOB) && area_ok_reg && !matched_reg &&
                      (total_reg >= TRACK_LIM);
    assign evict    = (op_reg == OP_FRAME) && (total_reg != '0) &&
                      (head_age_reg > cfg.max_age);
    assign diff_out = head_sx_reg - head_cx_reg;
    assign diff_in  = head_cx_reg - head_sx_reg;
    assign go_out   = (head_sx_reg > head_cx_reg) &&
                      (CMP_W'(diff_out) > CMP_W'(cfg.travel_threshold));
    assign go_in    = (head_cx_reg > head_sx_reg) &&
                      (CMP_W'(diff_in) > CMP_W'(cfg.travel_threshold));

    // Select the write port source: walk write-back or append
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = rd_addr_reg;
        wsx    = rd_sx_reg;
        wcx    = rd_cx_reg;
        wcy    = rd_cy_reg;
        wage   = rd_age_reg;
        if (rd_vld_reg)
        begin
            if (op_reg == OP_FRAME)
            begin
                mem_we = 1'b1;
                wage   = age_inc;
            end
            else if (hit)
            begin
                mem_we = 1'b1;
                wcx    = cx_reg;
                wcy    = cy_reg;
                wage   = '0;
            end
        end
        else if (cmd.finish && append)
        begin
            mem_we = 1'b1;
            waddr  = ring_addr(head_reg, total_reg);
            wsx    = cx_reg;
            wcx    = cx_reg;
            wcy    = cy_reg;
            wage   = '0;
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_sx[waddr]  <= wsx;
            mem_cx[waddr]  <= wcx;
            mem_cy[waddr]  <= wcy;
            mem_age[waddr] <= wage;
        end
        if (issue)
        begin
            rd_sx_reg  <= mem_sx[raddr];
            rd_cx_reg  <= mem_cx[raddr];
            rd_cy_reg  <= mem_cy[raddr];
            rd_age_reg <= mem_age[raddr];
        end
    end

    // Commit values
    always_comb
    begin
        head_next      = head_reg;
        total_next     = total_reg;
        tally_in_next  = tally_in_reg;
        tally_out_next = tally_out_reg;
        ev_next        = EV_NONE;
        if (append)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (drop)
        begin
            ev_next = EV_DROP;
        end
        else if (evict)
        begin
            head_next  = ring_addr(head_reg, CNT_W'(1));
            total_next = total_reg - 1'b1;
            if (go_out)
            begin
                ev_next = EV_OUT;
                if (tally_out_reg != '1)
                begin
                    tally_out_next = tally_out_reg + 1'b1;
                end
            end
            else if (go_in)
            begin
                ev_next = EV_IN;
                if (tally_in_reg != '1)
                begin
                    tally_in_next = tally_in_reg + 1'b1;
                end
            end
            else
            begin
                ev_next = EV_EVICT;
            end
        end
    end

    // Item capture and per-entry work, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op;
            area_ok_reg <= (area_x2 > cfg.min_area_x2) && (area_x2 < cfg.max_area_x2);
            bx_reg      <= to_coord(box_x);
            by_reg      <= to_coord(box_y);
            bw_reg      <= to_coord(box_w);
            bh_reg      <= to_coord(box_h);
            cx_reg      <= center(to_coord(box_x), to_coord(box_w));
            cy_reg      <= center(to_coord(box_y), to_coord(box_h));
        end
        if (issue)
        begin
            rd_addr_reg <= raddr;
        end
        if (rd_vld_reg && rd_first_reg && op_reg == OP_FRAME)
        begin
            head_sx_reg  <= rd_sx_reg;
            head_cx_reg  <= rd_cx_reg;
            head_age_reg <= age_inc;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            matched_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            tally_in_reg  <= '0;
            tally_out_reg <= '0;
            ev_reg        <= EV_NONE;
        end
        else
        begin
            rd_vld_reg   <= issue;
            rd_first_reg <= issue && (idx_reg == '0);
            if (cmd.load)
            begin
                idx_reg     <= '0;
                matched_reg <= 1'b0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (hit)
            begin
                matched_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                head_reg      <= head_next;
                total_reg     <= total_next;
                tally_in_reg  <= tally_in_next;
                tally_out_reg <= tally_out_next;
                ev_reg        <= ev_next;
            end
        end
    end

    // Counters only move at commit, so they serve as the result fields
    assign held_ext    = (CNT_W+HELD_W)'(total_reg);
    assign event_res   = ev_reg;
    assign count_in    = tally_in_reg;
    assign count_out   = tally_out_reg;
    assign tracks_held = held_ext[HELD_W-1:0];

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TRACK_LIM)
        else $error("track count beyond table depth");
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !rd_vld_reg)
        else $error("commit before the walk drained");
    a_frame_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && op_reg == OP_FRAME) |=> total_reg <= $past(total_reg))
        else $error("end of frame grew the table");
`endif

endmodule

`default_nettype wire

[rtl/blob_track_direction_counter.sv]
// Sequence: an accepted item is captured, then the track memory is walked one entry per cycle;
// nothing is walked for an empty table or a blob outside the area window; then the result is committed.
// Items: a new item is accepted only after the previous one is committed, and a result not yet
// taken holds the commit of the next item, and so its acceptance.
// Reset (rst_n, asynchronous, active low) empties the table, clears the tallies and loads
// the register defaults; track memory contents stay undefined until written.
`default_nettype none

module blob_track_direction_counter #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [btdc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [btdc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [btdc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              op,
    input  wire logic [btdc_pkg::FIELD_W-1:0]      box_x,
    input  wire logic [btdc_pkg::FIELD_W-1:0]      box_y,
    input  wire logic [btdc_pkg::FIELD_W-1:0]      box_w,
    input  wire logic [btdc_pkg::FIELD_W-1:0]      box_h,
    input  wire logic [btdc_pkg::AREA_W-1:0]       area_x2,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [btdc_pkg::EVENT_W-1:0]      event_res,
    output logic      [btdc_pkg::TALLY_W-1:0]      count_in,
    output logic      [btdc_pkg::TALLY_W-1:0]      count_out,
    output logic      [btdc_pkg::HELD_W-1:0]       tracks_held
);
    import btdc_pkg::*;

    cfg_t       cfg;
    ctl_cmd_t   cmd;
    dp_status_t status;

    // Configuration registers
    btdc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing
    btdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Track table and arithmetic
    btdc_dp #(
        .MAX_TRACKS (MAX_TRACKS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .op          (op),
        .box_x       (box_x),
        .box_y       (box_y),
        .box_w       (box_w),
        .box_h       (box_h),
        .area_x2     (area_x2),
        .event_res   (event_res),
        .count_in    (count_in),
        .count_out   (count_out),
        .tracks_held (tracks_held)
    );

endmodule

`default_nettype wire
